// File: sv/wep_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wep_pkg
// Types and codes shared by the wave element placement unit.
// ----------------------------------------------------------------------------
package wep_pkg;

	typedef enum logic [2:0] {
		CFG_SLOT_SIZE       = 3'd0,
		CFG_BANK_SIZE       = 3'd1,
		CFG_CHIP_SIZE       = 3'd2,
		CFG_CHIP_BASES      = 3'd3,
		CFG_DIRECTORY_COUNT = 3'd4,
		CFG_REVERSE_MASK    = 3'd5,
		CFG_LOOP_MODE_MASK  = 3'd6
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_BAD_DIR     = 4'd1,
		ST_BAD_MODE    = 4'd2,
		ST_START_END   = 4'd3,
		ST_LOOP_OUT    = 4'd4,
		ST_SIZE_ZERO   = 4'd5,
		ST_CROSS_CHIP  = 4'd6,
		ST_CHIP_RANGE  = 4'd7,
		ST_CROSS_BANK  = 4'd8,
		ST_BANK_RANGE  = 4'd9
	} status_t;

	localparam logic [1:0] MODE_FWD_LOOP = 2'd0;
	localparam logic [1:0] MODE_PINGPONG = 2'd1;
	localparam logic [1:0] MODE_FWD_ONCE = 2'd2;
	localparam logic [1:0] MODE_REV_ONCE = 2'd3;

	typedef struct packed {
		logic [1:0]  directory;
		logic [23:0] start_address;
		logic [23:0] loop_address;
		logic [23:0] end_address;
		logic [7:0]  control_byte;
	} in_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [1:0]  play_mode;
		logic        reverse_flag;
		logic [7:0]  chip_number;
		logic [4:0]  bank_number;
		logic [23:0] chip_offset;
		logic [23:0] start_in_bank;
		logic [23:0] loop_in_bank;
		logic [23:0] end_in_bank;
	} out_t;

endpackage
`default_nettype wire

// File: sv/wep_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wep_div
// Pipelined restoring divider, ceil(N / STAGES) quotient bits per stage, with sideband.
// ----------------------------------------------------------------------------
module wep_div #(
	parameter int N      = 24,
	parameter int D      = 25,
	parameter int STAGES = 6,
	parameter int SW     = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [N-1:0]  dividend,
	input  wire logic [D-1:0]  divisor,
	input  wire logic [SW-1:0] side_in,
	output logic               out_valid,
	output logic [N-1:0]       quotient,
	output logic [SW-1:0]      side_out
);
	localparam int BPS = (N + STAGES - 1) / STAGES;
	localparam int W   = BPS * STAGES;

	logic          vld_q [STAGES];
	logic [W-1:0]  dd_q  [STAGES];
	logic [W-1:0]  quo_q [STAGES];
	logic [D-1:0]  rem_q [STAGES];
	logic [D-1:0]  dsr_q [STAGES];
	logic [SW-1:0] side_q[STAGES];

	// stage inputs: the ports for the first stage, the previous stage after
	logic [W-1:0]  dd_i  [STAGES];
	logic [W-1:0]  quo_i [STAGES];
	logic [D-1:0]  rem_i [STAGES];
	logic [D-1:0]  dsr_i [STAGES];

	logic [W-1:0]  dd_n  [STAGES];
	logic [W-1:0]  quo_n [STAGES];
	logic [D-1:0]  rem_n [STAGES];

	always_comb begin
		dd_i[0]  = W'(dividend);
		quo_i[0] = '0;
		rem_i[0] = '0;
		dsr_i[0] = divisor;
		for (int k = 1; k < STAGES; k++) begin
			dd_i[k]  = dd_q[k-1];
			quo_i[k] = quo_q[k-1];
			rem_i[k] = rem_q[k-1];
			dsr_i[k] = dsr_q[k-1];
		end
	end

	always_comb begin
		logic [D:0]   t;
		logic [W-1:0] dd;
		logic [W-1:0] q;
		logic [D-1:0] r;
		logic [D-1:0] ds;
		for (int k = 0; k < STAGES; k++) begin
			dd = dd_i[k];
			q  = quo_i[k];
			r  = rem_i[k];
			ds = dsr_i[k];
			for (int j = 0; j < BPS; j++) begin
				t  = {r, dd[W-1]};
				dd = {dd[W-2:0], 1'b0};
				q  = {q[W-2:0], 1'b0};
				if (t >= {1'b0, ds}) begin
					t    = t - {1'b0, ds};
					q[0] = 1'b1;
				end
				r = t[D-1:0];
			end
			dd_n[k]  = dd;
			quo_n[k] = q;
			rem_n[k] = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STAGES; k++) vld_q[k] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < STAGES; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_in;
			for (int k = 0; k < STAGES; k++) begin
				dd_q[k]  <= dd_n[k];
				quo_q[k] <= quo_n[k];
				rem_q[k] <= rem_n[k];
				dsr_q[k] <= dsr_i[k];
			end
			for (int k = 1; k < STAGES; k++) side_q[k] <= side_q[k-1];
		end
	end

	assign out_valid = vld_q[STAGES-1];
	assign quotient  = quo_q[STAGES-1][N-1:0];
	assign side_out  = side_q[STAGES-1];

endmodule
`default_nettype wire

// File: sv/wave_element_placement_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wave_element_placement_unit
// Checks a wave element record and places it on a sample chip and bank.
// ----------------------------------------------------------------------------
// One result beat per input beat, one beat per cycle sustained. The stages are
// a decode stage, a six-stage start / slot_size divider (run beside a
// six-stage chip_size / bank_size divider), a slot base multiply, a chip check
// stage, a six-stage offset / bank_size divider, a multiply stage, then the
// bank check and result assembly feeding the output register. The whole pipe
// advances together; it holds only while a result sits in the output register
// untaken.
// Configuration writes are always ready and must only occur while idle.
// ----------------------------------------------------------------------------
module wave_element_placement_unit #(
	parameter int CHIP_COUNT    = 8,
	parameter int BANK_COUNT    = 32,
	parameter int DIRECTORY_MAX = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire wep_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output wep_pkg::out_t      out_data,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [31:0]   cfg_data
);
	import wep_pkg::*;

	// config registers
	logic [24:0] slot_size_q, bank_size_q, chip_size_q;
	logic [31:0] chip_bases_q;
	logic [2:0]  dir_count_q;
	logic [7:0]  rev_mask_q, mode_mask_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_size_q  <= '0;
			bank_size_q  <= '0;
			chip_size_q  <= '0;
			chip_bases_q <= '0;
			dir_count_q  <= '0;
			rev_mask_q   <= '0;
			mode_mask_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_SLOT_SIZE:       slot_size_q  <= cfg_data[24:0];
				CFG_BANK_SIZE:       bank_size_q  <= cfg_data[24:0];
				CFG_CHIP_SIZE:       chip_size_q  <= cfg_data[24:0];
				CFG_CHIP_BASES:      chip_bases_q <= cfg_data;
				CFG_DIRECTORY_COUNT: dir_count_q  <= cfg_data[2:0];
				CFG_REVERSE_MASK:    rev_mask_q   <= cfg_data[7:0];
				CFG_LOOP_MODE_MASK:  mode_mask_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// global advance: stall only when the output beat is held
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// ---- stage 1: early checks --------------------------------------------
	logic [3:0]  st_d;
	logic [1:0]  mode_d;
	logic        rev_d;
	logic [7:0]  mraw;

	always_comb begin
		st_d   = ST_OK;
		rev_d  = (in_data.control_byte & rev_mask_q) != 8'd0;
		mraw   = in_data.control_byte & mode_mask_q;
		mode_d = mraw[1:0];
		if (rev_d && mraw == 8'd2) mode_d = MODE_REV_ONCE;
		if ({1'b0, in_data.directory} >= dir_count_q ||
		    32'(in_data.directory) >= 32'(DIRECTORY_MAX)) begin
			st_d   = ST_BAD_DIR;
			rev_d  = 1'b0;
			mode_d = MODE_FWD_LOOP;
		end else if (mraw > 8'd2) begin
			st_d   = ST_BAD_MODE;
			mode_d = MODE_FWD_LOOP;
		end else if (in_data.start_address > in_data.end_address) begin
			st_d = ST_START_END;
		end else if (mode_d < MODE_FWD_ONCE &&
		             (in_data.loop_address < in_data.start_address ||
		              in_data.loop_address > in_data.end_address)) begin
			st_d = ST_LOOP_OUT;
		end else if (slot_size_q == 25'd0 || bank_size_q == 25'd0) begin
			st_d = ST_SIZE_ZERO;
		end
	end

	logic        v_s1;
	logic [3:0]  st_s1;
	logic [1:0]  mode_s1;
	logic        rev_s1;
	logic [1:0]  dir_s1;
	logic [23:0] start_s1, loop_s1, end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1    <= st_d;
			mode_s1  <= mode_d;
			rev_s1   <= rev_d;
			dir_s1   <= in_data.directory;
			start_s1 <= in_data.start_address;
			loop_s1  <= in_data.loop_address;
			end_s1   <= in_data.end_address;
		end
	end

	// ---- slot divider and banks-per-chip divider ---------------------------
	localparam int SIDE1_W = 4 + 2 + 1 + 72;
	logic               v_d1, v_b1;
	logic [23:0]        slot_d1;
	logic [24:0]        bpc_d1;
	logic [SIDE1_W-1:0] side1_o;
	logic [1:0]         dir_d1;

	wep_div #(.N(24), .D(25), .STAGES(6), .SW(SIDE1_W)) u_slot_div (
		.clk, .arst_n, .en,
		.in_valid (v_s1),
		.dividend (start_s1),
		.divisor  (slot_size_q),
		.side_in  ({st_s1, mode_s1, rev_s1, start_s1, loop_s1, end_s1}),
		.out_valid(v_d1),
		.quotient (slot_d1),
		.side_out (side1_o)
	);

	wep_div #(.N(25), .D(25), .STAGES(6), .SW(2)) u_bpc_div (
		.clk, .arst_n, .en,
		.in_valid (v_s1),
		.dividend (chip_size_q),
		.divisor  (bank_size_q),
		.side_in  (dir_s1),
		.out_valid(v_b1),
		.quotient (bpc_d1),
		.side_out (dir_d1)
	);

	// ---- stage 3: slot base ----------------------------------------------
	logic        v_s3;
	logic [SIDE1_W-1:0] side_s3;
	logic [23:0] slot_s3, sbase_s3;
	logic [24:0] bpc_s3;
	logic [1:0]  dir_s3;
	logic [48:0] sprod;

	assign sprod = slot_d1 * slot_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_d1 && v_b1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3  <= side1_o;
			slot_s3  <= slot_d1;
			sbase_s3 <= sprod[23:0];
			bpc_s3   <= bpc_d1;
			dir_s3   <= dir_d1;
		end
	end

	// ---- stage 4: chip crossing and range --------------------------------
	logic [3:0]  st3;
	logic [1:0]  mode3;
	logic        rev3;
	logic [23:0] start3, loop3, end3;
	assign {st3, mode3, rev3, start3, loop3, end3} = side_s3;

	logic [3:0]  st4_d;
	logic [24:0] chip4;
	logic [25:0] slot_lim;
	logic [7:0]  cbase;

	always_comb begin
		cbase    = chip_bases_q[8*dir_s3 +: 8];
		chip4    = 25'(cbase) + 25'(slot_s3);
		slot_lim = 26'(sbase_s3) + 26'(slot_size_q);
		st4_d    = st3;
		if (st3 == ST_OK) begin
			if (26'(end3) >= slot_lim)                 st4_d = ST_CROSS_CHIP;
			else if (chip4 >= 25'(CHIP_COUNT))        st4_d = ST_CHIP_RANGE;
		end
	end

	logic        v_s4;
	logic [3:0]  st_s4;
	logic [1:0]  mode_s4;
	logic        rev_s4;
	logic [7:0]  chip_s4;
	logic [24:0] bpc_s4;
	logic [23:0] sbase_s4, coff_s4, start_s4, loop_s4, end_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s4    <= st4_d;
			mode_s4  <= mode3;
			rev_s4   <= rev3;
			chip_s4  <= chip4[7:0];
			bpc_s4   <= bpc_s3;
			sbase_s4 <= sbase_s3;
			coff_s4  <= start3 - sbase_s3;
			start_s4 <= start3;
			loop_s4  <= loop3;
			end_s4   <= end3;
		end
	end

	// ---- bank-within-chip divider ----------------------------------------
	localparam int SIDE2_W = 4 + 2 + 1 + 8 + 25 + 24 * 5;
	logic               v_d2;
	logic [23:0]        within_d2;
	logic [SIDE2_W-1:0] side2_o;

	wep_div #(.N(24), .D(25), .STAGES(6), .SW(SIDE2_W)) u_bank_div (
		.clk, .arst_n, .en,
		.in_valid (v_s4),
		.dividend (coff_s4),
		.divisor  (bank_size_q),
		.side_in  ({st_s4, mode_s4, rev_s4, chip_s4, bpc_s4, sbase_s4, coff_s4,
		            start_s4, loop_s4, end_s4}),
		.out_valid(v_d2),
		.quotient (within_d2),
		.side_out (side2_o)
	);

	logic [3:0]  st5;
	logic [1:0]  mode5;
	logic        rev5;
	logic [7:0]  chip5;
	logic [24:0] bpc5;
	logic [23:0] sbase5, coff5, start5, loop5, end5;
	assign {st5, mode5, rev5, chip5, bpc5, sbase5, coff5, start5, loop5, end5} = side2_o;

	// ---- stage 6: products -----------------------------------------------
	logic [48:0] wprod;
	assign wprod = within_d2 * bank_size_q;

	logic        v_s6;
	logic [3:0]  st_s6;
	logic [1:0]  mode_s6;
	logic        rev_s6;
	logic [7:0]  chip_s6;
	logic [23:0] within_s6, wprod_s6, sbase_s6, coff_s6, start_s6, loop_s6, end_s6;
	logic [32:0] bprod_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_d2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s6     <= st5;
			mode_s6   <= mode5;
			rev_s6    <= rev5;
			chip_s6   <= chip5;
			within_s6 <= within_d2;
			wprod_s6  <= wprod[23:0];
			bprod_s6  <= chip5 * bpc5;
			sbase_s6  <= sbase5;
			coff_s6   <= coff5;
			start_s6  <= start5;
			loop_s6   <= loop5;
			end_s6    <= end5;
		end
	end

	// ---- bank crossing and range, result assembly ------------------------
	logic [23:0] bbase;
	logic [25:0] bank_lim;
	logic [33:0] bank7;
	out_t        res;

	always_comb begin
		bbase    = sbase_s6 + wprod_s6;
		bank_lim = 26'(sbase_s6) + 26'(wprod_s6) + 26'(bank_size_q);
		bank7    = 34'(bprod_s6) + 34'(within_s6);
		res              = '0;
		res.status       = st_s6;
		res.play_mode    = mode_s6;
		res.reverse_flag = rev_s6;
		if (st_s6 == ST_OK) begin
			if (26'(end_s6) >= bank_lim)           res.status = ST_CROSS_BANK;
			else if (bank7 >= 34'(BANK_COUNT))    res.status = ST_BANK_RANGE;
			else begin
				res.chip_number   = chip_s6;
				res.bank_number   = bank7[4:0];
				res.chip_offset   = coff_s6;
				res.start_in_bank = start_s6 - bbase;
				res.loop_in_bank  = loop_s6 - bbase;
				res.end_in_bank   = end_s6 - bbase;
			end
		end
	end

	logic out_valid_q;
	out_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire
